// ===== hw/rtl/weighted_moving_average_multichannel_defines.svh =====
// assertion macros for the weighted moving average block
// expect clk_i and rst_ni in the scope where they are used
`ifndef WEIGHTED_MOVING_AVERAGE_MULTICHANNEL_DEFINES_SVH
`define WEIGHTED_MOVING_AVERAGE_MULTICHANNEL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wma_pkg.sv =====
// shared types and constants of the weighted moving average block
// no dependencies
`timescale 1ns / 1ps

package wma_pkg;

  localparam int CHANNELS     = 3;
  localparam int MAX_WINDOW   = 255;
  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_RESET = 25;

  localparam int CH_W       = 2;
  localparam int WIN_W      = 8;
  localparam int PTR_W      = $clog2(MAX_WINDOW + 1);
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_AW    = CHAN_IDX_W + PTR_W;
  localparam int HIST_DEPTH = CHANNELS * (2 ** PTR_W);

  localparam int PSUM_W = SAMPLE_BITS + PTR_W;
  localparam int WSUM_W = SAMPLE_BITS + 2 * PTR_W;
  localparam int PROD_W = SAMPLE_BITS + PTR_W + 1;
  localparam int DEN_W  = 2 * PTR_W - 1;
  localparam int DVD_W  = WSUM_W + 1;
  localparam int DVS_W  = DEN_W + 1;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0]               out_channel;
    logic signed [SAMPLE_BITS-1:0] mean;
  } out_rsp_t;

  // per-channel running state
  typedef struct packed {
    logic                     filled;
    logic [PTR_W-1:0]         ptr;
    logic signed [PSUM_W-1:0] psum;
    logic signed [WSUM_W-1:0] wsum;
  } chan_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHRD,
    S_HRD,
    S_PREP,
    S_DIV,
    S_DONE
  } wma_state_e;

endpackage

// ===== hw/rtl/weighted_moving_average_multichannel.sv =====
// request path: S_CHRD, S_HRD, S_PREP, S_DIV, S_DONE; unknown channel jumps to S_DONE
// one request at a time, taken only in S_IDLE; the divider runs 33 bit-serial steps
// a finished result waits in the output register while the next request is taken
// reset: window 25, all channel histories, pointers and sums read as zero
// a window write clears all channels at once through per-channel valid bits
`timescale 1ns / 1ps
`include "weighted_moving_average_multichannel_defines.svh"

module weighted_moving_average_multichannel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wma_pkg::WIN_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wma_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wma_pkg::out_rsp_t           out_rsp_o
);
  import wma_pkg::*;

  // control
  wma_state_e            state_q, state_d;
  logic [WIN_W-1:0]      win_q;
  logic [PTR_W-1:0]      n_eff;
  logic [CHANNELS-1:0]   chan_vld_q;
  logic                  out_valid_q;
  logic                  accept;
  logic                  in_range;
  logic                  hist_we;
  logic                  div_start;
  logic                  out_load;

  // request and per-channel datapath
  in_req_t               cmd_q;
  logic                  range_ok_q;
  logic                  vld_rd_q;
  logic [CHAN_IDX_W-1:0] in_idx;
  logic [CHAN_IDX_W-1:0] cmd_idx;
  chan_state_t           chan_mem [CHANNELS];
  chan_state_t           chan_rd_q;
  chan_state_t           st_cur;
  chan_state_t           st_q;
  chan_state_t           st_new;
  logic [PTR_W:0]        ptr_inc;
  logic                  wrap;

  // history ring, one region of 2**PTR_W slots per channel
  logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  logic signed [SAMPLE_BITS-1:0] hist_rd_q;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic [HIST_AW-1:0]            hist_raddr;
  logic [HIST_AW-1:0]            hist_waddr;

  // arithmetic
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      prod_q;
  logic [2*PTR_W:0]              tri2;
  logic [DEN_W-1:0]              den_q;
  logic signed [WSUM_W-1:0]      wsum_q;
  logic signed [DVD_W-1:0]       wsum_ext;
  logic [DVD_W-1:0]              mag;
  logic [DVD_W-1:0]              dividend;
  logic [DVS_W-1:0]              divisor;
  logic                          neg_q;
  div_stat_t                     div_stat;
  logic [SAMPLE_BITS-1:0]        quot;
  logic [SAMPLE_BITS-1:0]        mean;
  out_rsp_t                      out_rsp_q;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = ($unsigned(in_req_i.channel) < CHANNELS);
  assign in_idx   = CHAN_IDX_W'(in_req_i.channel);
  assign cmd_idx  = CHAN_IDX_W'(cmd_q.channel);

  // window of zero acts as one, larger than MAX_WINDOW acts as MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      n_eff = PTR_W'(1);
    end else if (win_q > WIN_W'(MAX_WINDOW)) begin
      n_eff = PTR_W'(MAX_WINDOW);
    end else begin
      n_eff = PTR_W'(win_q);
    end
  end

  // sequencer: read channel state, read oldest sample, update, divide, hand off
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    hist_we    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // unknown channel skips straight to a zero result
          state_d = in_range ? S_CHRD : S_DONE;
        end
      end
      S_CHRD: begin
        state_d = S_HRD;
      end
      S_HRD: begin
        hist_we = 1'b1;
        state_d = S_PREP;
      end
      S_PREP: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // output register frees up as the pending result is taken
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= WIN_W'(WINDOW_RESET);
      chan_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      // window write drops every channel back to its zero state
      if (cfg_we_i) begin
        chan_vld_q <= '0;
      end else if (hist_we) begin
        chan_vld_q[cmd_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // channel state as read: invalid entries read as zero, stale pointer wraps
  always_comb begin
    st_cur = vld_rd_q ? chan_rd_q : '0;
    if (st_cur.ptr >= n_eff) begin
      st_cur.ptr = '0;
    end
  end

  assign hist_raddr = {cmd_idx, st_cur.ptr};
  assign hist_waddr = {cmd_idx, st_q.ptr};

  // n times sample and twice the triangular number, both from the clamped window
  assign prod = $signed({1'b0, n_eff}) * cmd_q.sample;
  assign tri2 = {1'b0, n_eff} * ({1'b0, n_eff} + 1'b1);

  // running sum update; slots not yet written in this fill read as zero
  always_comb begin
    oldest      = st_q.filled ? hist_rd_q : '0;
    ptr_inc     = {1'b0, st_q.ptr} + 1'b1;
    wrap        = (ptr_inc >= {1'b0, n_eff});
    st_new.wsum = st_q.wsum - WSUM_W'(st_q.psum) + WSUM_W'(prod_q);
    st_new.psum = st_q.psum - PSUM_W'(oldest) + PSUM_W'(cmd_q.sample);
    st_new.ptr  = wrap ? '0 : ptr_inc[PTR_W-1:0];
    st_new.filled = st_q.filled | wrap;
  end

  // divider operands: (2|w| + den) / (2 den) rounds half away from zero
  assign wsum_ext = DVD_W'(wsum_q);
  assign mag      = wsum_q[WSUM_W-1] ? DVD_W'(-wsum_ext) : DVD_W'(wsum_ext);
  assign dividend = {mag[DVD_W-2:0], 1'b0} + DVD_W'(den_q);
  assign divisor  = {den_q, 1'b0};

  wma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  always_comb begin
    if (!range_ok_q) begin
      mean = '0;
    end else if (neg_q) begin
      mean = -quot;
    end else begin
      mean = quot;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_req_i;
      range_ok_q <= in_range;
      vld_rd_q   <= in_range ? chan_vld_q[in_idx] : 1'b0;
    end
    if (state_q == S_CHRD) begin
      st_q   <= st_cur;
      prod_q <= prod;
      den_q  <= tri2[DEN_W:1];
    end
    if (state_q == S_HRD) begin
      wsum_q <= st_new.wsum;
    end
    if (state_q == S_PREP) begin
      neg_q <= wsum_q[WSUM_W-1];
    end
    if (out_load) begin
      out_rsp_q.out_channel <= cmd_q.channel;
      out_rsp_q.mean        <= mean;
    end
  end

  // channel state memory
  always_ff @(posedge clk_i) begin
    if (accept && in_range) begin
      chan_rd_q <= chan_mem[in_idx];
    end
    if (hist_we) begin
      chan_mem[cmd_idx] <= st_new;
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHRD) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
    if (hist_we) begin
      hist_mem[hist_waddr] <= cmd_q.sample;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `WMA_ASSERT_NXT(a_cfg_clears_valid, cfg_we_i, chan_vld_q == '0,
                  "window write did not clear channel state")
  `WMA_ASSERT_IMP(a_hist_wr_in_range, hist_we, range_ok_q,
                  "history write for unknown channel")
  `WMA_ASSERT_IMP(a_out_from_done, $rose(out_valid_o), $past(state_q == S_DONE),
                  "result appeared outside hand-off")
  `WMA_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == S_DIV,
                  "divider finished while sequencer not waiting")

endmodule

// ===== hw/rtl/wma_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on wma_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "weighted_moving_average_multichannel_defines.svh"

module wma_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [wma_pkg::DVD_W-1:0]          dividend_i,
  input  logic [wma_pkg::DVS_W-1:0]          divisor_i,
  output wma_pkg::div_stat_t                 stat_o,
  output logic [wma_pkg::SAMPLE_BITS-1:0]    quot_o
);
  import wma_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     divisor_q;
  logic [DVD_W-1:0]     quo_q;

  logic [DVS_W:0]       rem_shift;
  logic [DVS_W+1:0]     diff;
  logic                 qbit;
  logic [DVS_W-1:0]     rem_next;

  always_comb begin
    rem_shift = {rem_q, quo_q[DVD_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, divisor_q};
    qbit      = !diff[DVS_W+1];
    rem_next  = qbit ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DVD_W-2:0], qbit};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q[SAMPLE_BITS-1:0];

  `WMA_ASSERT_NXT(a_div_start_busy, start_i, stat_o.busy, "divider not busy after start")
  `WMA_ASSERT_IMP(a_div_done_idle, stat_o.done, !stat_o.busy, "divider done while busy")
  `WMA_ASSERT_IMP(a_div_rem_bound, busy_q && !start_i, rem_q < divisor_q,
                  "divider remainder not below divisor")

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for weighted_moving_average_multichannel
// depends on wma_pkg and the block's rtl; predicts every mean and checks it in order
`timescale 1ns / 1ps

module tb;

  import wma_pkg::*;

  typedef enum int {
    MIX_FULL,
    MIX_RAIL,
    MIX_SMALL
  } sample_mix_e;

  // per-channel weighted mean predictor plus the queue of means still owed
  class channel_means;
    logic [WIN_W-1:0]               window;
    logic signed [SAMPLE_BITS-1:0]  hist [CHANNELS][MAX_WINDOW];
    int                             ptr [CHANNELS];
    longint                         psum [CHANNELS];
    longint                         wsum [CHANNELS];
    out_rsp_t                       owed_means [$];
    int                             mismatches;
    int                             checked;

    function new();
      window     = WIN_W'(WINDOW_RESET);
      mismatches = 0;
      checked    = 0;
      clear();
    endfunction

    function void clear();
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < MAX_WINDOW; k++) hist[c][k] = '0;
        ptr[c]  = 0;
        psum[c] = 0;
        wsum[c] = 0;
      end
    endfunction

    // a window write also wipes every channel
    function void set_window(logic [WIN_W-1:0] w);
      window = w;
      clear();
    endfunction

    function int pending();
      return owed_means.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // accepted request: update the channel and queue its mean
    function void take_sample(in_req_t req);
      out_rsp_t want;
      longint   n, s, oldest, den, mag, q;
      int       c, p;
      want.out_channel = req.channel;
      want.mean        = '0;
      if (req.channel < CHANNELS) begin
        c = req.channel;
        n = (window == 0) ? 1 : window;
        if (n > MAX_WINDOW) n = MAX_WINDOW;
        p = ptr[c];
        if (p >= n) p = 0;
        s       = $signed(req.sample);
        oldest  = hist[c][p];
        wsum[c] = wsum[c] - psum[c] + n * s;
        psum[c] = psum[c] - oldest + s;
        hist[c][p] = req.sample;
        ptr[c]  = (p + 1 >= n) ? 0 : p + 1;
        // round to nearest, ties away from zero
        den = n * (n + 1) / 2;
        mag = (wsum[c] < 0) ? -wsum[c] : wsum[c];
        q   = (2 * mag + den) / (2 * den);
        if (wsum[c] < 0) q = -q;
        want.mean = q[SAMPLE_BITS-1:0];
      end
      owed_means.push_back(want);
    endfunction

    function void check_mean(out_rsp_t got);
      out_rsp_t want;
      if (owed_means.size() == 0) begin
        flag($sformatf("mean %0d on channel %0d with nothing owed",
                       $signed(got.mean), got.out_channel));
        return;
      end
      want = owed_means.pop_front();
      checked++;
      if (got.out_channel !== want.out_channel)
        flag($sformatf("out_channel exp %0d got %0d", want.out_channel, got.out_channel));
      if (got.mean !== want.mean)
        flag($sformatf("mean on channel %0d exp %0d got %0d", want.out_channel,
                       $signed(want.mean), $signed(got.mean)));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_req_t          in_req = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_rsp_t         out_rsp;

  channel_means means;
  bit           quiet = 1'b0;      // no idling on either side while set
  int unsigned  ready_left = 0;
  int unsigned  ready_pick;
  int           requests_sent = 0;
  int           stray_requests = 0;
  int           windows_used = 1;

  weighted_moving_average_multichannel u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: ready held at a level for a random stretch, mostly short stalls
  always @(posedge clk) begin
    if (quiet) begin
      out_ready  <= 1'b1;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      ready_pick = $urandom_range(99);
      if (ready_pick < 60) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(7);
      end else if (ready_pick < 90) begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(2);
      end else begin
        out_ready  <= 1'b0;
        ready_left <= $urandom_range(80, 20);
      end
    end
  end

  // every mean leaving the block is checked against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) means.check_mean(out_rsp);
  end

  // sender idle before a request; lowers valid only when a gap is taken
  task automatic sender_gap();
    int unsigned pick, len;
    pick = $urandom_range(99);
    if (quiet || pick < 55) len = 0;
    else if (pick < 92) len = $urandom_range(3, 1);
    else len = $urandom_range(60, 10);
    if (len != 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // present one request and hold it until the block takes it
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] s);
    in_req_t req;
    req.channel = ch;
    req.sample  = s;
    sender_gap();
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    means.take_sample(req);
    requests_sent++;
    if (ch >= CHANNELS) stray_requests++;
  endtask

  // stop sending and wait until every owed mean has come back
  task automatic drain_means();
    in_valid <= 1'b0;
    @(posedge clk);
    while (means.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    drain_means();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    means.set_window(w);
    windows_used++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(sample_mix_e mix, logic [CH_W-1:0] ch);
    int small_val;
    case (mix)
      MIX_RAIL: begin
        // rails push the running sums to their largest magnitudes
        if ($urandom_range(9) == 0) return SAMPLE_BITS'($urandom);
        if (ch == 0) return 16'h7fff;
        if (ch == 1) return 16'h8000;
        return $urandom_range(1) ? 16'h7fff : 16'h8000;
      end
      MIX_SMALL: begin
        // small values make rounding ties common
        small_val = int'($urandom_range(32)) - 16;
        return SAMPLE_BITS'(small_val);
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(99) < 6) return CH_W'(CHANNELS);
    return CH_W'($urandom_range(CHANNELS - 1));
  endfunction

  // one window setting with a stream of random requests
  task automatic run_window(input logic [WIN_W-1:0] w, input int count);
    sample_mix_e     mix;
    logic [CH_W-1:0] ch;
    mix = MIX_FULL;
    write_window(w);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        mix   = sample_mix_e'($urandom_range(2));
        quiet = ($urandom_range(99) < 15);
      end
      // occasional full pause mid-stream
      if ($urandom_range(199) == 0) drain_means();
      ch = pick_channel();
      send_sample(ch, pick_sample(mix, ch));
    end
    quiet = 1'b0;
  endtask

  initial begin
    means = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 25: rails, zero, minus one, stray channel
    send_sample(2'd0, 16'h7fff);
    send_sample(2'd1, 16'h8000);
    send_sample(2'd2, 16'hffff);
    send_sample(CH_W'(CHANNELS), 16'h5a5a);
    send_sample(2'd0, 16'h0000);
    send_sample(2'd1, 16'h0001);
    send_sample(CH_W'(CHANNELS), 16'hffff);

    // window 3: halves round away from zero on both signs
    write_window(8'd3);
    send_sample(2'd0, 16'd1);
    send_sample(2'd1, 16'hffff);
    send_sample(2'd2, 16'd3);
    send_sample(2'd2, 16'hfffd);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd0, 16'h7fff);
    send_sample(2'd0, 16'h7fff);

    // window 0 behaves as a window of one: samples pass straight through
    write_window(8'd0);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd1, 16'h7fff);
    send_sample(2'd2, 16'h1234);
    send_sample(CH_W'(CHANNELS), 16'h0000);

    // random part over several windows, extremes included
    run_window(8'd255, 600);
    run_window(8'd1, 100);
    run_window(8'd2, 120);
    run_window(8'd0, 80);
    run_window(8'd3, 100);
    run_window(WIN_W'($urandom_range(40, 4)), 200);
    run_window(WIN_W'($urandom_range(255, 1)), 150);
    run_window(8'd128, 100);

    drain_means();
    repeat (60) @(posedge clk);

    $display("covered %0d sample requests over %0d window settings, %0d on the unused channel",
             requests_sent, windows_used, stray_requests);
    $display("checked %0d means, %0d mismatches", means.checked, means.mismatches);
    if (means.mismatches == 0 && means.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("timeout with %0d means still owed", means.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wma_pkg.sv
hw/rtl/wma_div.sv
hw/rtl/weighted_moving_average_multichannel.sv
sim/tb.sv
